// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_pkg
// Types, widths, curve tables and the control program of the voltage to
// capacity lookup.
// ----------------------------------------------------------------------------
package bvc_pkg;

    localparam int CURVE_POINTS = 21;
    localparam int NUM_CURVES   = 7;

    localparam int VOLT_W = 13;
    localparam int TEMP_W = 12;
    localparam int PCT_W  = 7;
    localparam int DT_W   = TEMP_W + 1;
    localparam int LVL_W  = 10;
    localparam int WT_W   = 8;
    localparam int DEN_W  = 10;
    localparam int DIV_W  = 18;
    localparam int DC_W   = $clog2(DIV_W + 1);
    localparam int CK_W   = $clog2(NUM_CURVES + 1);
    localparam int CI_W   = $clog2(NUM_CURVES);
    localparam int PT_W   = $clog2(CURVE_POINTS + 1);
    localparam int PI_W   = $clog2(CURVE_POINTS);
    localparam int UPC_W  = 4;

    localparam int SCALE_MAX = 1000;
    localparam int PCT_MAX   = 100;
    localparam int STEP      = SCALE_MAX / (CURVE_POINTS - 1);

    // (x * PCT_RECIP) >> PCT_SHIFT equals x / PCT_DIV for x up to 1028
    localparam int PCT_DIV   = SCALE_MAX / PCT_MAX;
    localparam int PCT_RECIP = 205;
    localparam int PCT_SHIFT = 11;

    localparam logic signed [TEMP_W-1:0] CURVE_TEMP [NUM_CURVES] = '{
        12'sd250, 12'sd60, 12'sd10, -12'sd30, -12'sd70, -12'sd100, -12'sd150
    };

    localparam logic [VOLT_W-1:0] CURVE_MV [NUM_CURVES][CURVE_POINTS] = '{
        '{13'd3578, 13'd3615, 13'd3645, 13'd3669, 13'd3688, 13'd3703, 13'd3716,
          13'd3727, 13'd3739, 13'd3754, 13'd3772, 13'd3793, 13'd3821, 13'd3852,
          13'd3883, 13'd3915, 13'd3948, 13'd3984, 13'd4023, 13'd4065, 13'd4126},
        '{13'd3498, 13'd3562, 13'd3593, 13'd3615, 13'd3633, 13'd3648, 13'd3660,
          13'd3673, 13'd3688, 13'd3705, 13'd3724, 13'd3747, 13'd3772, 13'd3799,
          13'd3830, 13'd3863, 13'd3898, 13'd3936, 13'd3976, 13'd4019, 13'd4091},
        '{13'd3459, 13'd3522, 13'd3558, 13'd3581, 13'd3598, 13'd3613, 13'd3626,
          13'd3640, 13'd3656, 13'd3674, 13'd3695, 13'd3718, 13'd3743, 13'd3771,
          13'd3801, 13'd3834, 13'd3869, 13'd3908, 13'd3949, 13'd3992, 13'd4068},
        '{13'd3404, 13'd3466, 13'd3502, 13'd3528, 13'd3547, 13'd3563, 13'd3578,
          13'd3594, 13'd3611, 13'd3630, 13'd3652, 13'd3675, 13'd3700, 13'd3729,
          13'd3758, 13'd3791, 13'd3826, 13'd3865, 13'd3907, 13'd3955, 13'd4039},
        '{13'd3338, 13'd3390, 13'd3426, 13'd3453, 13'd3475, 13'd3494, 13'd3512,
          13'd3529, 13'd3548, 13'd3569, 13'd3592, 13'd3617, 13'd3642, 13'd3670,
          13'd3700, 13'd3733, 13'd3768, 13'd3805, 13'd3847, 13'd3896, 13'd3997},
        '{13'd3269, 13'd3302, 13'd3330, 13'd3354, 13'd3376, 13'd3398, 13'd3418,
          13'd3439, 13'd3460, 13'd3482, 13'd3506, 13'd3531, 13'd3558, 13'd3587,
          13'd3617, 13'd3650, 13'd3684, 13'd3722, 13'd3765, 13'd3818, 13'd3940},
        '{13'd3238, 13'd3254, 13'd3270, 13'd3284, 13'd3300, 13'd3314, 13'd3330,
          13'd3344, 13'd3360, 13'd3374, 13'd3390, 13'd3404, 13'd3420, 13'd3433,
          13'd3448, 13'd3461, 13'd3473, 13'd3487, 13'd3524, 13'd3643, 13'd3845}
    };

    typedef enum logic [3:0] {
        OP_TSRCH,   // walk the temperature list
        OP_SETUP,   // latch bracket curves, start on the hotter one
        OP_PSRCH,   // walk the points of the current curve
        OP_SEG,     // load segment fraction into the divider
        OP_DIV,     // one restoring divide step
        OP_LVL,     // store curve level, maybe switch curves
        OP_MULHI,   // hot curve times its weight
        OP_MULLO,   // add cold curve times its weight, load divider
        OP_PCT,     // scale blend to percent by reciprocal multiply
        OP_DONE     // hand result to the output register
    } uop_t;

    typedef enum logic [1:0] {
        JC_NEXT,    // always advance
        JC_HOLD,    // repeat while the step flag is set
        JC_BRANCH,  // jump to target when the flag is set
        JC_END      // hold while flag set, then go idle
    } ucond_t;

    typedef struct packed {
        uop_t             op;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    localparam logic [UPC_W-1:0] UA_PSRCH = 4'd2;

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_DONE, cond: JC_END, target: '0};
        unique case (addr)
            4'd0:    w = '{op: OP_TSRCH, cond: JC_HOLD,   target: '0};
            4'd1:    w = '{op: OP_SETUP, cond: JC_NEXT,   target: '0};
            4'd2:    w = '{op: OP_PSRCH, cond: JC_HOLD,   target: '0};
            4'd3:    w = '{op: OP_SEG,   cond: JC_NEXT,   target: '0};
            4'd4:    w = '{op: OP_DIV,   cond: JC_HOLD,   target: '0};
            4'd5:    w = '{op: OP_LVL,   cond: JC_BRANCH, target: UA_PSRCH};
            4'd6:    w = '{op: OP_MULHI, cond: JC_NEXT,   target: '0};
            4'd7:    w = '{op: OP_MULLO, cond: JC_NEXT,   target: '0};
            4'd8:    w = '{op: OP_DIV,   cond: JC_HOLD,   target: '0};
            4'd9:    w = '{op: OP_PCT,   cond: JC_NEXT,   target: '0};
            4'd10:   w = '{op: OP_DONE,  cond: JC_END,    target: '0};
            default: w = '{op: OP_DONE,  cond: JC_END,    target: '0};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/battery_voltage_to_capacity_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_to_capacity_top
// Open-circuit-voltage to charge lookup with temperature blending, run by a
// small microprogram over one shared serial divider.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_stall, voltage_mv,       | in
//           | temp_decideg                          |
//   output  | out_valid, out_stall, capacity_pct    | out
//
// One item at a time: the time from accept to result is set by the
// temperature search, the point search on one or two curves and two or
// three 18-step passes of the shared restoring divider; the percent scaling
// is one reciprocal multiply. in_stall is high from accept until the result
// is loaded into the output register; the next item is taken while that
// result waits on out_stall.
// Reset (rst_n low) clears the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
module battery_voltage_to_capacity_top
    import bvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [VOLT_W-1:0]        voltage_mv,
    input  logic signed [TEMP_W-1:0] temp_decideg,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [PCT_W-1:0]         capacity_pct
);

    // control
    logic              busy_reg, busy_next;
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic              oval_reg, oval_next;
    logic              pass_reg, pass_next;
    logic [CK_W-1:0]   tk_reg, tk_next;
    logic [PT_W-1:0]   pt_reg, pt_next;
    logic [DC_W-1:0]   dcnt_reg, dcnt_next;

    // datapath
    logic [VOLT_W-1:0]        mv_reg, mv_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [CI_W-1:0]          hi_reg, hi_next;
    logic [CI_W-1:0]          lo_reg, lo_next;
    logic [CI_W-1:0]          curve_reg, curve_next;
    logic [LVL_W-1:0]         lvl_hi_reg, lvl_hi_next;
    logic [LVL_W-1:0]         lvl_lo_reg, lvl_lo_next;
    logic [LVL_W-1:0]         base_reg, base_next;
    logic [DIV_W-1:0]         num_reg, num_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [PCT_W-1:0]         pct_reg, pct_next;

    uword_t uw;
    logic   accept;
    logic   step_flag;
    logic   out_free;

    logic [CI_W-1:0]          tk_idx, hi_sel, lo_sel;
    logic signed [TEMP_W-1:0] t_cur, t_hi, t_lo;
    logic                     tsrch_more;

    logic [PI_W-1:0]   pt_idx, pt_prev_idx;
    logic [VOLT_W-1:0] pv_cur, pv_prev, seg_off, seg_span;
    logic              psrch_more;
    logic [DIV_W-1:0]  seg_num;
    logic [LVL_W-1:0]  seg_base;

    logic [DEN_W:0]    trial, trial_diff;
    logic              trial_ge;

    logic [DIV_W-1:0]  lvl_sum;
    logic [LVL_W-1:0]  lvl_val;

    logic                  single;
    logic signed [DT_W-1:0] w_hi_full, w_lo_full, span_full;
    logic [WT_W-1:0]       w_hi, w_lo;
    logic [DEN_W-1:0]      t_span;
    logic [DIV_W-1:0]      prod_hi, prod_lo, pct_sum, pct_prod, pct_num;

    assign uw        = ucode_rom(upc_reg);
    assign accept    = in_valid && !busy_reg;
    assign out_free  = !oval_reg || !out_stall;
    assign in_stall  = busy_reg;
    assign out_valid = oval_reg;
    assign capacity_pct = pct_reg;

    // temperature bracket
    always_comb
    begin
        tk_idx     = (tk_reg < CK_W'(NUM_CURVES)) ? tk_reg[CI_W-1:0] : CI_W'(NUM_CURVES - 1);
        t_cur      = CURVE_TEMP[tk_idx];
        tsrch_more = (tk_reg < CK_W'(NUM_CURVES)) && (temp_reg < t_cur);
        hi_sel     = (tk_reg == '0) ? '0 : CI_W'(tk_reg - 1'b1);
        lo_sel     = (tk_reg == CK_W'(NUM_CURVES)) ? CI_W'(NUM_CURVES - 1) : tk_reg[CI_W-1:0];
    end

    // point search and segment setup
    always_comb
    begin
        pt_idx      = (pt_reg < PT_W'(CURVE_POINTS)) ? pt_reg[PI_W-1:0]
                                                     : PI_W'(CURVE_POINTS - 1);
        pt_prev_idx = (pt_reg != '0) ? PI_W'(pt_reg - 1'b1) : '0;
        pv_cur      = CURVE_MV[curve_reg][pt_idx];
        pv_prev     = CURVE_MV[curve_reg][pt_prev_idx];
        psrch_more  = (pt_reg < PT_W'(CURVE_POINTS)) && (mv_reg >= pv_cur);
        seg_off     = mv_reg - pv_prev;
        seg_span    = pv_cur - pv_prev;
        seg_num     = DIV_W'(seg_off) * DIV_W'(STEP);
        seg_base    = LVL_W'(DIV_W'(pt_prev_idx) * DIV_W'(STEP));
    end

    // divider step, level saturation, blend weights
    always_comb
    begin
        trial      = {rem_reg, num_reg[DIV_W-1]};
        trial_ge   = trial >= {1'b0, den_reg};
        trial_diff = trial - {1'b0, den_reg};

        lvl_sum = DIV_W'(base_reg) + num_reg;
        lvl_val = (lvl_sum > DIV_W'(SCALE_MAX)) ? LVL_W'(SCALE_MAX) : lvl_sum[LVL_W-1:0];

        single    = (hi_reg == lo_reg);
        t_hi      = CURVE_TEMP[hi_reg];
        t_lo      = CURVE_TEMP[lo_reg];
        w_hi_full = DT_W'(temp_reg) - DT_W'(t_lo);
        w_lo_full = DT_W'(t_hi) - DT_W'(temp_reg);
        span_full = DT_W'(t_hi) - DT_W'(t_lo);
        w_hi      = w_hi_full[WT_W-1:0];
        w_lo      = w_lo_full[WT_W-1:0];
        t_span    = span_full[DEN_W-1:0];
        prod_hi   = DIV_W'(lvl_hi_reg) * DIV_W'(w_hi);
        prod_lo   = DIV_W'(lvl_lo_reg) * DIV_W'(w_lo);

        // blend * 100 / 1000 rounded half up is (blend + 5) / 10
        pct_sum   = DIV_W'(num_reg[LVL_W-1:0]) + DIV_W'(PCT_DIV / 2);
        pct_prod  = pct_sum * DIV_W'(PCT_RECIP);
        pct_num   = pct_prod >> PCT_SHIFT;
    end

    // condition flag of the current step
    always_comb
    begin
        unique case (uw.op)
            OP_TSRCH: step_flag = tsrch_more;
            OP_PSRCH: step_flag = psrch_more;
            OP_DIV:   step_flag = (dcnt_reg != DC_W'(1));
            OP_LVL:   step_flag = !pass_reg && !single;
            OP_DONE:  step_flag = !out_free;
            default:  step_flag = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            upc_next  = '0;
        end
        else if (busy_reg)
        begin
            unique case (uw.cond)
                JC_NEXT:   upc_next = upc_reg + 1'b1;
                JC_HOLD:   upc_next = step_flag ? upc_reg : upc_reg + 1'b1;
                JC_BRANCH: upc_next = step_flag ? uw.target : upc_reg + 1'b1;
                JC_END:
                begin
                    if (!step_flag)
                    begin
                        busy_next = 1'b0;
                        upc_next  = '0;
                    end
                end
                default:   upc_next = upc_reg;
            endcase
        end
    end

    // datapath control decode
    always_comb
    begin
        mv_next     = mv_reg;
        temp_next   = temp_reg;
        tk_next     = tk_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        curve_next  = curve_reg;
        pt_next     = pt_reg;
        pass_next   = pass_reg;
        lvl_hi_next = lvl_hi_reg;
        lvl_lo_next = lvl_lo_reg;
        base_next   = base_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        pct_next    = pct_reg;
        oval_next   = oval_reg && out_stall;

        if (accept)
        begin
            mv_next   = voltage_mv;
            temp_next = temp_decideg;
            tk_next   = '0;
        end
        else if (busy_reg)
        begin
            unique case (uw.op)
                OP_TSRCH:
                begin
                    if (tsrch_more)
                        tk_next = tk_reg + 1'b1;
                end
                OP_SETUP:
                begin
                    hi_next    = hi_sel;
                    lo_next    = lo_sel;
                    curve_next = hi_sel;
                    pt_next    = '0;
                    pass_next  = 1'b0;
                end
                OP_PSRCH:
                begin
                    if (psrch_more)
                        pt_next = pt_reg + 1'b1;
                end
                OP_SEG:
                begin
                    rem_next  = '0;
                    dcnt_next = DC_W'(DIV_W);
                    if (pt_reg == '0)
                    begin
                        num_next  = '0;
                        den_next  = DEN_W'(1);
                        base_next = '0;
                    end
                    else if (pt_reg == PT_W'(CURVE_POINTS))
                    begin
                        num_next  = '0;
                        den_next  = DEN_W'(1);
                        base_next = LVL_W'(SCALE_MAX);
                    end
                    else
                    begin
                        num_next  = seg_num;
                        den_next  = seg_span[DEN_W-1:0];
                        base_next = seg_base;
                    end
                end
                OP_DIV:
                begin
                    dcnt_next = dcnt_reg - 1'b1;
                    if (trial_ge)
                    begin
                        rem_next = trial_diff[DEN_W-1:0];
                        num_next = {num_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[DEN_W-1:0];
                        num_next = {num_reg[DIV_W-2:0], 1'b0};
                    end
                end
                OP_LVL:
                begin
                    if (!pass_reg)
                    begin
                        lvl_hi_next = lvl_val;
                        pass_next   = 1'b1;
                        curve_next  = lo_reg;
                        pt_next     = '0;
                    end
                    else
                    begin
                        lvl_lo_next = lvl_val;
                    end
                end
                OP_MULHI:
                begin
                    num_next = single ? DIV_W'(lvl_hi_reg) : prod_hi;
                end
                OP_MULLO:
                begin
                    rem_next  = '0;
                    dcnt_next = DC_W'(DIV_W);
                    if (single)
                    begin
                        den_next = DEN_W'(1);
                    end
                    else
                    begin
                        // round to nearest, half up
                        num_next = num_reg + prod_lo + DIV_W'(t_span >> 1);
                        den_next = t_span;
                    end
                end
                OP_PCT:
                begin
                    num_next = pct_num;
                end
                OP_DONE:
                begin
                    if (out_free)
                    begin
                        pct_next  = num_reg[PCT_W-1:0];
                        oval_next = 1'b1;
                    end
                end
                default:
                begin
                    pct_next = pct_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
            oval_reg <= 1'b0;
            pass_reg <= 1'b0;
            tk_reg   <= '0;
            pt_reg   <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            oval_reg <= oval_next;
            pass_reg <= pass_next;
            tk_reg   <= tk_next;
            pt_reg   <= pt_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg     <= mv_next;
        temp_reg   <= temp_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        curve_reg  <= curve_next;
        lvl_hi_reg <= lvl_hi_next;
        lvl_lo_reg <= lvl_lo_next;
        base_reg   <= base_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        pct_reg    <= pct_next;
    end

endmodule

// ===== rtl/bvc_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvc_chk
// Port-level checks of the voltage to capacity lookup, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvc_chk
    import bvc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [VOLT_W-1:0]        voltage_mv,
    input logic signed [TEMP_W-1:0] temp_decideg,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [PCT_W-1:0]         capacity_pct
);

    // a stalled result holds
    `BVC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(capacity_pct), "stalled result changed")

    // result is a percentage
    `BVC_ASSERT_NOW(a_pct_range, out_valid,
        capacity_pct <= PCT_W'(PCT_MAX), "capacity above 100 percent")

    // an accepted item keeps the input stalled while it is worked on
    `BVC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall,
        in_stall && !$rose(out_valid), "input not stalled after accept")

    // a new result appears only as the block frees its input
    `BVC_ASSERT_NOW(a_result_frees_input, $rose(out_valid),
        !in_stall && $past(in_stall), "result without finishing an item")

endmodule

bind battery_voltage_to_capacity_top bvc_chk u_bvc_chk (.*);
